// File: rtl/gdft_pkg.sv
// Package for the depth-first graph traversal block: field widths, codes and types.
// Used by the channel interfaces, the edge store and the top level.
`timescale 1ns / 1ps
package gdft_pkg;
  localparam int VERTEX_W = 6;
  localparam int STATUS_W = 2;
  localparam int DEF_NUM_VERTICES = 64;
  localparam int DEF_MAX_EDGES = 256;

  typedef enum logic [1:0] {
    ST_VISIT   = 2'd0,
    ST_STORED  = 2'd1,
    ST_DROPPED = 2'd2,
    ST_NONE    = 2'd3
  } status_t;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_WALK = 1'b1
  } op_t;

  typedef struct packed {
    logic                op;
    logic [VERTEX_W-1:0] src_vertex;
    logic [VERTEX_W-1:0] dst_vertex;
  } in_item_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic [STATUS_W-1:0] status;
    logic                last;
  } out_item_t;
endpackage

// File: rtl/gdft_in_if.sv
// Input channel interface of the traversal block: valid, ready and one input item.
// Depends on gdft_pkg.
`timescale 1ns / 1ps
interface gdft_in_if import gdft_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/gdft_out_if.sv
// Output channel interface of the traversal block: valid, ready and one result item.
// Depends on gdft_pkg.
`timescale 1ns / 1ps
interface gdft_out_if import gdft_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/graph_depth_first_traversal.sv
// Depth-first traversal of a directed graph held as adjacency lists in synchronous
// memories. An edge load goes from its transfer to its result (stored, or dropped when
// the store is full or a vertex is out of range), and no new input is taken before that
// result is loaded. A traversal starts with the transfer and a pass that clears the
// visited marks vertex by vertex. It then tries the roots in turn and fetches a root's
// list head when the root is visited. Each edge followed goes through step, edge
// memory read and check, plus a fetch of the list head when the edge reaches a new
// vertex. A stack pop goes through step and pop, or step alone when it empties the
// stack, and the traversal closes in an end state. Each visit is held back by one and
// delivered when the next one is found, so the final visit can carry last. A traversal
// that visits nothing gives one result with status 3. A result waiting for the receiver
// stalls the walk at its next visit and holds the input off.
`timescale 1ns / 1ps
module graph_depth_first_traversal import gdft_pkg::*; #(
  parameter int NUM_VERTICES = DEF_NUM_VERTICES,
  parameter int MAX_EDGES = DEF_MAX_EDGES
) (
  input logic clk,
  input logic rst,
  gdft_in_if.sink    in_ch,
  gdft_out_if.source out_ch
);
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int LW = $clog2(MAX_EDGES + 1);
  localparam int VW = $clog2(NUM_VERTICES);
  localparam int DW = $clog2(NUM_VERTICES + 1);
  localparam logic [LW-1:0] NULL_LINK = LW'(MAX_EDGES);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_EDGE  = 10'b0000000010,
    S_CLEAR = 10'b0000000100,
    S_ROOT  = 10'b0000001000,
    S_HEAD  = 10'b0000010000,
    S_STEP  = 10'b0000100000,
    S_POP   = 10'b0001000000,
    S_READ  = 10'b0010000000,
    S_CHECK = 10'b0100000000,
    S_END   = 10'b1000000000
  } state_t;

  state_t state;
  logic [LW-1:0] list_head [NUM_VERTICES];
  logic [LW-1:0] stack_next [NUM_VERTICES];
  logic [NUM_VERTICES-1:0] has_outgoing;
  logic [NUM_VERTICES-1:0] visited_mark;
  logic [DW-1:0] stack_depth;
  logic [LW-1:0] top_next;
  logic [LW-1:0] edge_count;
  logic [VW-1:0] root;
  logic [VW-1:0] clr_idx;
  logic          any_visit;
  logic [VERTEX_W-1:0] held_vertex;
  logic          head_null;
  logic [LW-1:0] cur_edge;
  in_item_t      req;
  logic [LW-1:0] head_rd;
  logic [LW-1:0] stack_rd;

  logic out_valid;
  out_item_t out_data;

  logic          wr_en;
  logic [VERTEX_W-1:0] rd_target;
  logic [LW-1:0] rd_link;
  logic [DW-1:0] top;
  logic [DW-1:0] below;
  logic          out_free;
  logic          edge_ok;
  logic [VW-1:0] tgt;
  logic [VW-1:0] src_idx;
  logic [LW-1:0] src_head;
  logic [VW-1:0] head_addr;
  logic          root_new;
  logic          tgt_new;
  logic          push_ok;
  logic          out_load;
  out_item_t     out_next;

  assign top = stack_depth - DW'(1);
  assign below = stack_depth - DW'(2);
  assign out_free = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && out_free;
  assign out_ch.valid = out_valid;
  assign out_ch.data = out_data;
  assign edge_ok = (edge_count < LW'(MAX_EDGES))
      && (32'(req.src_vertex) < NUM_VERTICES) && (32'(req.dst_vertex) < NUM_VERTICES);
  assign wr_en = (state == S_EDGE) && edge_ok;
  assign tgt = VW'(rd_target);
  assign src_idx = VW'(req.src_vertex);
  assign src_head = has_outgoing[src_idx] ? head_rd : NULL_LINK;
  assign root_new = has_outgoing[root] && !visited_mark[root];
  assign tgt_new = !visited_mark[tgt];
  assign push_ok = (state == S_CHECK) && tgt_new && out_free
      && (32'(stack_depth) < NUM_VERTICES);

  gdft_edge_mem #(.MAX_EDGES(MAX_EDGES), .AW(AW), .LW(LW)) u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr(AW'(edge_count)), .wr_target(req.dst_vertex),
    .wr_link(src_head), .rd_addr(AW'(cur_edge)),
    .rd_target(rd_target), .rd_link(rd_link)
  );

  // The list head is read for the incoming source, the root or the new target.
  always_comb begin
    if (state == S_IDLE) head_addr = VW'(in_ch.data.src_vertex);
    else if (state == S_ROOT) head_addr = root;
    else head_addr = tgt;
  end

  // List heads and stacked edge pointers: one write and one registered read each.
  // A list head is only trusted once its vertex has an outgoing edge.
  always_ff @(posedge clk) begin
    if (wr_en) list_head[src_idx] <= edge_count;
    head_rd <= list_head[head_addr];
    if (push_ok) stack_next[VW'(top)] <= rd_link;
    stack_rd <= stack_next[VW'(below)];
  end

  // Result to load this cycle; a visit releases the one held back before it.
  always_comb begin
    out_load = 1'b0;
    out_next = '0;
    unique case (state)
      S_EDGE: begin
        out_load = 1'b1;
        out_next.status = edge_ok ? ST_STORED : ST_DROPPED;
        out_next.last = 1'b1;
      end
      S_ROOT: begin
        out_load = root_new && any_visit && out_free;
        out_next.vertex = held_vertex;
        out_next.status = ST_VISIT;
      end
      S_CHECK: begin
        out_load = tgt_new && any_visit && out_free;
        out_next.vertex = held_vertex;
        out_next.status = ST_VISIT;
      end
      S_END: begin
        out_load = out_free;
        out_next.vertex = any_visit ? held_vertex : '0;
        out_next.status = any_visit ? ST_VISIT : ST_NONE;
        out_next.last = 1'b1;
      end
      default: ;
    endcase
  end

  // Control sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      has_outgoing <= '0;
      visited_mark <= '0;
      edge_count <= '0;
      stack_depth <= '0;
      any_visit <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        out_data <= out_next;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            req <= in_ch.data;
            clr_idx <= '0;
            state <= (in_ch.data.op == OP_ADD) ? S_EDGE : S_CLEAR;
          end
        end
        S_EDGE: begin
          if (edge_ok) begin
            has_outgoing[src_idx] <= 1'b1;
            edge_count <= edge_count + LW'(1);
          end
          state <= S_IDLE;
        end
        S_CLEAR: begin
          visited_mark[clr_idx] <= 1'b0;
          clr_idx <= clr_idx + VW'(1);
          if (32'(clr_idx) == NUM_VERTICES - 1) begin
            root <= '0;
            any_visit <= 1'b0;
            stack_depth <= '0;
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (root_new) begin
            if (out_free) begin
              visited_mark[root] <= 1'b1;
              held_vertex <= VERTEX_W'(root);
              any_visit <= 1'b1;
              stack_depth <= DW'(1);
              head_null <= 1'b0;
              state <= S_HEAD;
            end
          end else if (32'(root) == NUM_VERTICES - 1) begin
            state <= S_END;
          end else begin
            root <= root + VW'(1);
          end
        end
        S_HEAD: begin
          top_next <= head_null ? NULL_LINK : head_rd;
          state <= S_STEP;
        end
        S_STEP: begin
          if (top_next == NULL_LINK) begin
            stack_depth <= top;
            state <= (top == '0) ? S_ROOT : S_POP;
          end else begin
            cur_edge <= top_next;
            state <= S_READ;
          end
        end
        S_POP: begin
          top_next <= stack_rd;
          state <= S_STEP;
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (!tgt_new) begin
            top_next <= rd_link;
            state <= S_STEP;
          end else if (out_free) begin
            visited_mark[tgt] <= 1'b1;
            held_vertex <= rd_target;
            any_visit <= 1'b1;
            if (push_ok) begin
              stack_depth <= stack_depth + DW'(1);
              head_null <= !has_outgoing[tgt];
              state <= S_HEAD;
            end else begin
              top_next <= rd_link;
              state <= S_STEP;
            end
          end
        end
        S_END: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // A result on offer stays unchanged until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data));
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state));
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    32'(stack_depth) <= NUM_VERTICES);
  a_edge_bound: assert property (@(posedge clk) disable iff (rst)
    32'(edge_count) <= MAX_EDGES);
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> state == S_IDLE);
`endif
endmodule

// File: rtl/gdft_edge_mem.sv
// Edge store: target vertex and link to the older edge of the same list, per edge.
// One write port and one registered read port. Depends on gdft_pkg.
`timescale 1ns / 1ps
module gdft_edge_mem import gdft_pkg::*; #(
  parameter int MAX_EDGES = DEF_MAX_EDGES,
  parameter int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  parameter int LW = $clog2(MAX_EDGES + 1)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic [VERTEX_W-1:0] wr_target,
  input  logic [LW-1:0]       wr_link,
  input  logic [AW-1:0]       rd_addr,
  output logic [VERTEX_W-1:0] rd_target,
  output logic [LW-1:0]       rd_link
);
  logic [VERTEX_W+LW-1:0] mem [MAX_EDGES];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_target, wr_link};
    end
    {rd_target, rd_link} <= mem[rd_addr];
  end
endmodule
